>>> design/fifo_queue_with_keyed_cancel_macros.svh
// Assertion macros shared by the queue RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIFO_QUEUE_WITH_KEYED_CANCEL_MACROS_SVH
`define FIFO_QUEUE_WITH_KEYED_CANCEL_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold in the same cycle as the trigger.
`define FQKC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define FQKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FQKC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define FQKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/fqkc_pkg.sv
// Shared types and codes for the keyed-cancel queue.
// Used by fqkc_ctrl, fqkc_dpath and the top level; no dependencies.
package fqkc_pkg;

  localparam int KEY_W  = 37;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int OCC_W  = 7;

  // Request codes carried on in_tuser
  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  // Result codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One stored queue entry
  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TAG_W-1:0]  record_tag;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    req_load;     // latch the accepted request
    logic    idx_clr;      // walk index back to the head
    logic    idx_inc;      // advance walk index
    logic    rd_walk;      // read entry at walk index
    logic    wr_enq;       // store request at the tail, count up
    logic    wr_shift;     // move read entry one place toward the head
    logic    head_inc;     // drop the head slot
    logic    count_dec;    // one entry fewer
    logic    out_load;     // load the result register
    status_t out_status;
    logic    out_use_data; // result carries the read entry, else zeros
    logic    out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_end;   // walk index equals count
    logic walk_last;  // walk index is the tail entry
    logic key_match;  // read entry key equals request key
    logic out_free;   // result register can take a new result
  } dp_stat_t;

endpackage

>>> design/fqkc_dpath.sv
// Datapath of the keyed-cancel queue: entry memory, ring pointers, walk
// index, request and result registers. Depends on fqkc_pkg and the macro header.
`include "fifo_queue_with_keyed_cancel_macros.svh"

module fqkc_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fqkc_pkg::dp_cmd_t          cmd,
  output fqkc_pkg::dp_stat_t         stat,
  input  logic [fqkc_pkg::KEY_W-1:0]  in_key,
  input  logic [fqkc_pkg::TAG_W-1:0]  in_tag,
  input  logic [fqkc_pkg::TIME_W-1:0] in_time,
  input  logic                       out_ready,
  output logic                       out_valid,
  output fqkc_pkg::status_t          out_status,
  output logic [fqkc_pkg::KEY_W-1:0]  out_key,
  output logic [fqkc_pkg::TAG_W-1:0]  out_tag,
  output logic [fqkc_pkg::TIME_W-1:0] out_time,
  output logic [fqkc_pkg::OCC_W-1:0]  out_occ,
  output logic                       out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Map a position counted from the head onto a memory slot
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, ofs};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  fqkc_pkg::entry_t entry_mem_r [DEPTH];
  fqkc_pkg::entry_t rdata_r;
  fqkc_pkg::entry_t req_r;
  logic [AW-1:0]    head_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    idx_prev;
  logic [AW-1:0]    rd_slot;
  logic [AW-1:0]    wr_slot;
  logic             wr_en;
  fqkc_pkg::entry_t wr_data;
  logic             out_valid_r;
  fqkc_pkg::status_t out_status_r;
  fqkc_pkg::entry_t out_entry_r;
  logic [fqkc_pkg::OCC_W-1:0] out_occ_r;
  logic             out_last_r;
  logic             out_free;

  // Address and write selection
  assign idx_prev = idx_r - CW'(1);
  assign rd_slot  = slot_of(head_r, idx_r[AW-1:0]);
  assign wr_en    = cmd.wr_enq | cmd.wr_shift;
  assign wr_slot  = cmd.wr_enq ? slot_of(head_r, count_r[AW-1:0])
                               : slot_of(head_r, idx_prev[AW-1:0]);
  assign wr_data  = cmd.wr_enq ? req_r : rdata_r;

  // Entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_slot] <= wr_data;
    end
    if (cmd.rd_walk) begin
      rdata_r <= entry_mem_r[rd_slot];
    end
  end

  // Request holding register
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= '{arrival_time: in_time, record_tag: in_tag, key: in_key};
    end
  end

  // Ring pointer, fill count and walk index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.head_inc) begin
        head_r <= slot_of(head_r, AW'(1));
      end
      if (cmd.wr_enq) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  // Result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_entry_r  <= cmd.out_use_data ? rdata_r : '0;
      out_occ_r    <= fqkc_pkg::OCC_W'(count_r);
      out_last_r   <= cmd.out_last;
    end
  end

  // Status toward the controller
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == DEPTH_C);
  assign stat.walk_end  = (idx_r == count_r);
  assign stat.walk_last = ((idx_r + CW'(1)) == count_r);
  assign stat.key_match = (rdata_r.key == req_r.key);
  assign stat.out_free  = out_free;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_entry_r.key;
  assign out_tag    = out_entry_r.record_tag;
  assign out_time   = out_entry_r.arrival_time;
  assign out_occ    = out_occ_r;
  assign out_last   = out_last_r;

  // Checks
  `FQKC_ASSERT_IMPL(a_enq_room, clk, rst_n, cmd.wr_enq, count_r < DEPTH_C, "enqueue write while full")
  `FQKC_ASSERT_IMPL(a_dec_nonempty, clk, rst_n, cmd.count_dec, count_r != '0, "count below zero")
  `FQKC_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, out_free, "result overwritten")
  `FQKC_ASSERT_NEXT(a_enq_count, clk, rst_n, rst_n && cmd.wr_enq, count_r == $past(count_r) + CW'(1), "enqueue did not count up")

endmodule

>>> design/fqkc_ctrl.sv
// Controller of the keyed-cancel queue: sequences enqueue, dequeue, cancel
// and list over the datapath. Depends on fqkc_pkg.
module fqkc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  output logic               in_ready,
  input  fqkc_pkg::dp_stat_t stat,
  output fqkc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ_RD,
    S_DEQ_POP,
    S_CAN_RD,
    S_CAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  fqkc_pkg::status_t resp_st_r, resp_st_nxt;
  logic              resp_data_r, resp_data_nxt;
  fqkc_pkg::action_t act;

  assign act = fqkc_pkg::action_t'(in_action);

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    resp_st_nxt   = resp_st_r;
    resp_data_nxt = resp_data_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.out_status = fqkc_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load  = 1'b1;
          cmd.idx_clr   = 1'b1;
          resp_data_nxt = 1'b0;
          case (act)
            fqkc_pkg::ACT_ENQ:    state_nxt = S_ENQ;
            fqkc_pkg::ACT_DEQ:    state_nxt = S_DEQ_RD;
            fqkc_pkg::ACT_CANCEL: state_nxt = S_CAN_RD;
            default:              state_nxt = S_LIST_RD;
          endcase
        end
      end
      S_ENQ: begin
        if (stat.full) begin
          resp_st_nxt = fqkc_pkg::ST_FULL;
        end else begin
          cmd.wr_enq  = 1'b1;
          resp_st_nxt = fqkc_pkg::ST_OK;
        end
        state_nxt = S_RESP;
      end
      S_DEQ_RD: begin
        if (stat.empty) begin
          resp_st_nxt = fqkc_pkg::ST_EMPTY;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_DEQ_POP;
        end
      end
      S_DEQ_POP: begin
        cmd.head_inc  = 1'b1;
        cmd.count_dec = 1'b1;
        resp_st_nxt   = fqkc_pkg::ST_OK;
        resp_data_nxt = 1'b1;
        state_nxt     = S_RESP;
      end
      // search from the head for the first matching key
      S_CAN_RD: begin
        if (stat.walk_end) begin
          resp_st_nxt = fqkc_pkg::ST_NOT_FOUND;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_CAN_CMP;
        end
      end
      S_CAN_CMP: begin
        cmd.idx_inc = 1'b1;
        state_nxt   = stat.key_match ? S_SHIFT_RD : S_CAN_RD;
      end
      // close the gap: each later entry moves one place toward the head
      S_SHIFT_RD: begin
        if (stat.walk_end) begin
          cmd.count_dec = 1'b1;
          resp_st_nxt   = fqkc_pkg::ST_OK;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      // list walks head to tail, one result per entry
      S_LIST_RD: begin
        if (stat.walk_end) begin
          resp_st_nxt = fqkc_pkg::ST_EMPTY;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_LIST_EMIT;
        end
      end
      S_LIST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_status   = fqkc_pkg::ST_OK;
          cmd.out_use_data = 1'b1;
          cmd.out_last     = stat.walk_last;
          cmd.idx_inc      = 1'b1;
          state_nxt        = stat.walk_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_status   = resp_st_r;
          cmd.out_use_data = resp_data_r;
          cmd.out_last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered response code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      resp_st_r   <= fqkc_pkg::ST_OK;
      resp_data_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resp_st_r   <= resp_st_nxt;
      resp_data_r <= resp_data_nxt;
    end
  end

endmodule

>>> design/fifo_queue_with_keyed_cancel.sv
// Channel   Dir  Handshake                  Payload
// in_*      in   in_tvalid / in_tready      tuser: action; tdata: key, tag, time
// out_*     out  out_tvalid / out_tready    tuser: status; tdata: key, tag, time, occ;
//                                           tlast: final result of a request
// Cancel and list walk the entries held from the head; each walked entry takes
// a read and then a compare, a move or an emit, on the one read port.
// Reset clears counters, pointers and control state, not the entries; no clearing pass.
// A stalled out_tready holds the result register; the next request is still
// taken and waits for it. One request is in work at a time.
// Top level of the keyed-cancel queue; depends on fqkc_pkg, fqkc_ctrl, fqkc_dpath.
module fifo_queue_with_keyed_cancel #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // key[36:0], record_tag[52:37], arrival_time[84:53]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_key[36:0], out_tag[52:37], out_time[84:53],
                                  // occupancy[91:85]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  fqkc_pkg::dp_cmd_t  cmd;
  fqkc_pkg::dp_stat_t stat;
  fqkc_pkg::status_t  out_status;
  logic [fqkc_pkg::KEY_W-1:0]  out_key;
  logic [fqkc_pkg::TAG_W-1:0]  out_tag;
  logic [fqkc_pkg::TIME_W-1:0] out_time;
  logic [fqkc_pkg::OCC_W-1:0]  out_occ;

  fqkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fqkc_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (in_tdata[36:0]),
    .in_tag     (in_tdata[52:37]),
    .in_time    (in_tdata[84:53]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_key    (out_key),
    .out_tag    (out_tag),
    .out_time   (out_time),
    .out_occ    (out_occ),
    .out_last   (out_tlast)
  );

  // Pack the result transaction
  assign out_tdata = {4'b0000, out_occ, out_time, out_tag, out_key};
  assign out_tuser = out_status;

endmodule
